// ===== sv/assert_macros.svh =====
// Assertion macros used by the sampler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== sv/hbs_pkg.sv =====
package hbs_pkg;

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_BILINEAR = 2'd1,
    OP_BICUBIC  = 2'd2,
    OP_NONE     = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Z = 3'd1,
    REG_INV_CELL = 3'd2,
    REG_GRID_W   = 3'd3,
    REG_GRID_H   = 3'd4
  } reg_index_t;

  localparam int CFG_DATA_W = 32;

  typedef struct packed {
    logic [1:0]  opcode;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_z;
    logic [6:0]  sample_row;
    logic [6:0]  sample_col;
    logic signed [31:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] height;
    logic        out_of_range;
    logic        used_bicubic;
  } out_item_t;

endpackage

// ===== sv/hbs_stream_if.sv =====
interface hbs_in_if;
  logic valid;
  logic ready;
  hbs_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface hbs_out_if;
  logic valid;
  logic ready;
  hbs_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/heightmap_bicubic_sampler.sv =====
// Heightmap sampler with bilinear and Catmull-Rom queries.
// Input channel "in": each beat is a sample write (no result) or a query
// (exactly one result beat on "out"). Opcode 3 is dropped with no result.
// Configuration: cfg_we / cfg_index / cfg_data, written while idle.
// Samples live in one single-port synchronous memory addressed by row and
// column, read one word per cycle. After a write beat the write state
// stores the sample and the control returns to idle for the next beat. A
// query passes S_MAP and S_CELL; then each sample read passes S_READ and
// S_WAIT and each Horner step S_MUL and S_ACC, while a query out of range
// goes straight to S_SAT, which loads the output register. The next beat
// can be taken in the same cycle that the result beat becomes valid. The
// sixteen memory reads and fifteen dependent multiplies of the Horner
// passes dominate the Catmull-Rom query.
// The result sits in an output register. While the receiver stalls it is
// held, one further item may be taken and worked on, and its result waits
// in the control until the register is free. Reset returns the control to
// idle and the registers to their reset values; the memory holds undefined
// data until written, and entries must be written before they are read.
module heightmap_bicubic_sampler #(
  parameter int MAX_COLS = 128,
  parameter int MAX_ROWS = 128
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [hbs_pkg::CFG_DATA_W-1:0] cfg_data,
  hbs_in_if.sink   in,
  hbs_out_if.source out
);
  `include "assert_macros.svh"

  localparam int CB = $clog2(MAX_COLS);
  localparam int RB = $clog2(MAX_ROWS);
  localparam int AW = CB + RB;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_WRITE = 10'b0000000010,
    S_MAP   = 10'b0000000100,
    S_CELL  = 10'b0000001000,
    S_READ  = 10'b0000010000,
    S_WAIT  = 10'b0000100000,
    S_PASS  = 10'b0001000000,
    S_MUL   = 10'b0010000000,
    S_ACC   = 10'b0100000000,
    S_SAT   = 10'b1000000000
  } state_t;

  state_t state, state_next;

  logic signed [31:0] origin_x, origin_z;
  logic [15:0] inv_cell;
  logic [7:0]  grid_w, grid_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0;
      origin_z <= '0;
      inv_cell <= 16'd1024;
      grid_w <= 8'd128;
      grid_h <= 8'd128;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hbs_pkg::REG_ORIGIN_X: origin_x <= cfg_data;
        hbs_pkg::REG_ORIGIN_Z: origin_z <= cfg_data;
        hbs_pkg::REG_INV_CELL: inv_cell <= cfg_data[15:0];
        hbs_pkg::REG_GRID_W:   grid_w <= cfg_data[7:0];
        hbs_pkg::REG_GRID_H:   grid_h <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Sample memory.
  logic [31:0] mem [1 << AW];
  logic        mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0] mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_rdata <= mem[mem_addr];
  end

  hbs_pkg::in_item_t item;
  logic accept;
  assign in.ready = (state == S_IDLE);
  assign accept = in.valid && in.ready;

  // Grid mapping.
  logic signed [32:0] dx, dz;
  logic signed [49:0] gx, gz;
  logic signed [25:0] ix, iz;
  logic [15:0] tx, tz;
  logic [10:0] w_eff, h_eff;
  logic bic, oor;
  logic signed [25:0] cx, cz, wl, hl;
  logic cell_bic, cell_oor;
  logic out_load;

  // Pass sequencing: row (0..3 bicubic, 0..1 bilinear), tap (0..3 / 0..1).
  logic [2:0] row;
  logic [1:0] tap;
  logic [2:0] step;
  logic signed [47:0] p [4];
  logic signed [47:0] colv [4];
  logic signed [47:0] acc, coef;
  logic signed [65:0] prod;
  logic signed [47:0] res;
  logic final_pass;

  logic signed [25:0] rd_r, rd_c;
  always_comb begin
    rd_r = bic ? iz - 26'sd1 + 26'(row) : iz + 26'(row);
    rd_c = bic ? ix - 26'sd1 + 26'(tap) : ix + 26'(tap);
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wdata = item.sample_value;
    mem_addr = AW'({rd_r[RB-1:0], rd_c[CB-1:0]});
    if (state == S_WRITE) begin
      mem_we = (32'(item.sample_row) < 32'(MAX_ROWS)) &&
               (32'(item.sample_col) < 32'(MAX_COLS));
      mem_addr = AW'({RB'(item.sample_row), CB'(item.sample_col)});
    end
  end

  function automatic logic signed [47:0] fshr(input logic signed [65:0] v);
    logic signed [65:0] s;
    s = v >>> 16;
    return s[47:0];
  endfunction

  logic signed [47:0] t_sel;
  assign t_sel = final_pass ? (bic ? {32'd0, tz} : {32'd0, tz}) : {32'd0, tx};

  // Build coefficients for a Horner pass: step 0 uses D, then C, B; A is added to the last product.
  logic signed [47:0] ca, cbv, cc, cd;
  logic signed [47:0] q0, q1, q2, q3;
  always_comb begin
    q0 = final_pass ? colv[0] : p[0];
    q1 = final_pass ? colv[1] : p[1];
    q2 = final_pass ? colv[2] : p[2];
    q3 = final_pass ? colv[3] : p[3];
    ca = q1 <<< 1;
    cbv = q2 - q0;
    cc = (q0 <<< 1) - (q1 <<< 2) - q1 + (q2 <<< 2) - q3;
    cd = q1 + (q1 <<< 1) - q2 - (q2 <<< 1) + q3 - q0;
    unique case (step)
      3'd0: coef = cd;
      3'd1: coef = cc;
      3'd2: coef = cbv;
      default: coef = ca;
    endcase
  end

  assign res = fshr(prod) + ca;

  logic [1:0] nrows, ntaps;
  assign nrows = bic ? 2'd3 : 2'd1;
  assign ntaps = bic ? 2'd3 : 2'd1;

  // A finished result moves into the output register once that is free.
  assign out_load = (state == S_SAT) && (!out.valid || out.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out.valid <= 1'b1;
      else if (out.ready) out.valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) begin
        unique case (in.payload.opcode)
          hbs_pkg::OP_WRITE: state_next = S_WRITE;
          hbs_pkg::OP_NONE:  state_next = S_IDLE;
          default:           state_next = S_MAP;
        endcase
      end
      S_WRITE: state_next = S_IDLE;
      S_MAP:   state_next = S_CELL;
      S_CELL:  state_next = cell_oor ? S_SAT : S_READ;
      S_READ:  state_next = S_WAIT;
      S_WAIT:  state_next = (tap == ntaps) ? S_PASS : S_READ;
      S_PASS:  state_next = S_MUL;
      S_MUL:   state_next = S_ACC;
      S_ACC: begin
        if ((bic && step != 3'd2) || (!bic && step != 3'd0)) state_next = S_MUL;
        else if (final_pass) state_next = S_SAT;
        else if (row == 3'(nrows)) state_next = S_PASS;
        else state_next = S_READ;
      end
      S_SAT:   state_next = out_load ? S_IDLE : S_SAT;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) item <= in.payload;
    unique case (state)
      S_MAP: begin
        dx <= 33'(signed'(item.coord_x)) - 33'(origin_x);
        dz <= 33'(signed'(item.coord_z)) - 33'(origin_z);
        w_eff <= (11'(grid_w) > 11'(MAX_COLS)) ? 11'(MAX_COLS) : 11'(grid_w);
        h_eff <= (11'(grid_h) > 11'(MAX_ROWS)) ? 11'(MAX_ROWS) : 11'(grid_h);
      end
      S_CELL: ;
      default: ;
    endcase
    if (state == S_CELL) begin
      row <= '0;
      tap <= '0;
      final_pass <= 1'b0;
    end
    if (state == S_WAIT) begin
      p[tap] <= 48'(signed'(mem_rdata));
      tap <= tap + 2'd1;
    end
    if (state == S_PASS) begin
      step <= '0;
      if (!bic) begin
        // Bilinear: acc = a; the multiply uses b - a directly.
        acc <= final_pass ? colv[0] : p[0];
      end else begin
        acc <= '0;
      end
    end
    if (state == S_MUL) begin
      if (bic) prod <= 66'(acc + coef) * 66'(t_sel);
      else prod <= 66'(final_pass ? colv[1] - colv[0] : p[1] - p[0]) * 66'(t_sel);
    end
    if (state == S_ACC) begin
      if (bic) begin
        if (step == 3'd2) begin
          if (final_pass) acc <= res >>> 1;
          else begin
            colv[row[1:0]] <= res >>> 1;
            row <= row + 3'd1;
            tap <= '0;
            if (row == 3'(nrows)) final_pass <= 1'b1;
          end
        end else begin
          acc <= fshr(prod);
          step <= step + 3'd1;
        end
      end else begin
        if (final_pass) acc <= acc + fshr(prod);
        else begin
          colv[row[1:0]] <= acc + fshr(prod);
          row <= row + 3'd1;
          tap <= '0;
          if (row == 3'(nrows)) final_pass <= 1'b1;
        end
      end
    end
    if (out_load) begin
      out.payload.out_of_range <= oor;
      out.payload.used_bicubic <= bic && !oor;
      if (oor) out.payload.height <= '0;
      else if (acc > 48'sd2147483647) out.payload.height <= 32'sh7fffffff;
      else if (acc < -48'sd2147483648) out.payload.height <= 32'sh80000000;
      else out.payload.height <= acc[31:0];
    end
  end

  // Cell decode, registered in S_CELL from the differences registered in S_MAP.
  always_comb begin
    gx = 50'(dx) * 50'(signed'({1'b0, inv_cell}));
    gz = 50'(dz) * 50'(signed'({1'b0, inv_cell}));
    cx = gx[49:24];
    cz = gz[49:24];
    wl = signed'(26'(w_eff));
    hl = signed'(26'(h_eff));
    cell_bic = (item.opcode == hbs_pkg::OP_BICUBIC) &&
               !(cx < 26'sd1 || cz < 26'sd1 || cx >= wl - 26'sd2 || cz >= hl - 26'sd2);
    cell_oor = !cell_bic &&
               (cx < 26'sd0 || cz < 26'sd0 || cx + 26'sd1 >= wl || cz + 26'sd1 >= hl);
  end

  always_ff @(posedge clk) begin
    if (state == S_CELL) begin
      ix <= cx;
      iz <= cz;
      tx <= gx[23:8];
      tz <= gz[23:8];
      bic <= cell_bic;
      oor <= cell_oor;
    end
  end

  `ASSERT_NEVER(a_no_accept_busy, clk, rst, in.ready && state != S_IDLE,
    "input accepted while busy")
  `ASSERT_IMPL(a_out_hold, clk, rst, out.valid && !out.ready |=> out.valid,
    "result dropped under stall")
  `ASSERT_NEVER(a_we_only_write, clk, rst, mem_we && state != S_WRITE,
    "memory written outside a write")
  `ASSERT_IMPL(a_payload_hold, clk, rst, out.valid && !out.ready |=> $stable(out.payload),
    "result changed under stall")

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;

  typedef enum {PATH_LIN, PATH_CUBIC, PATH_OUT} path_t;
  typedef struct {bit chk; hbs_pkg::out_item_t ex;} note_t;
  typedef struct {hbs_pkg::in_item_t it; bit chk; hbs_pkg::out_item_t ex;} row_t;

  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 50;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [hbs_pkg::CFG_DATA_W-1:0] cfg_data;

  hbs_in_if in_ch();
  hbs_out_if out_ch();

  heightmap_bicubic_sampler uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in(in_ch), .out(out_ch)
  );

  // Shadow of the register file and of the sample store.
  longint org_x, org_z, inv_cell;
  int grid_w, grid_h;
  logic signed [31:0] samples [16384];
  bit filled [16384];

  note_t note_q[$];
  hbs_pkg::out_item_t height_q[$];
  int errs;
  int idle_cycles;
  bit hold_req;
  int burst_left;
  int sent;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic hbs_pkg::in_item_t mk_in(hbs_pkg::opcode_t op, logic [31:0] x,
                                              logic [31:0] z, int r, int c,
                                              logic [31:0] v);
    hbs_pkg::in_item_t it;
    it.opcode = op;
    it.coord_x = x;
    it.coord_z = z;
    it.sample_row = r[6:0];
    it.sample_col = c[6:0];
    it.sample_value = v;
    return it;
  endfunction

  function automatic hbs_pkg::out_item_t mk_out(logic [31:0] h, bit oor, bit bic);
    hbs_pkg::out_item_t o;
    o.height = h;
    o.out_of_range = oor;
    o.used_bicubic = bic;
    return o;
  endfunction

  function automatic void locate(input hbs_pkg::in_item_t it, output longint ix,
                                 output longint iz, output longint tx, output longint tz,
                                 output path_t p);
    longint gx, gz, w, h;
    w = grid_w > 128 ? 128 : grid_w;
    h = grid_h > 128 ? 128 : grid_h;
    gx = (longint'(it.coord_x) - org_x) * inv_cell;
    gz = (longint'(it.coord_z) - org_z) * inv_cell;
    ix = gx >>> 24;
    iz = gz >>> 24;
    tx = (gx & 64'hFFFFFF) >> 8;
    tz = (gz & 64'hFFFFFF) >> 8;
    if (it.opcode == hbs_pkg::OP_BICUBIC &&
        !(ix < 1 || iz < 1 || ix >= w - 2 || iz >= h - 2))
      p = PATH_CUBIC;
    else if (ix < 0 || iz < 0 || ix + 1 >= w || iz + 1 >= h)
      p = PATH_OUT;
    else
      p = PATH_LIN;
  endfunction

  function automatic longint sample_at(longint r, longint c);
    return longint'(samples[r * 128 + c]);
  endfunction

  function automatic longint blend(longint a, longint b, longint t);
    return a + (((b - a) * t) >>> 16);
  endfunction

  function automatic longint spline(longint p0, longint p1, longint p2, longint p3,
                                    longint t);
    longint ca, cb, cc, cd, r;
    ca = 2 * p1;
    cb = p2 - p0;
    cc = 2 * p0 - 5 * p1 + 4 * p2 - p3;
    cd = -p0 + 3 * p1 - 3 * p2 + p3;
    r = ((cd * t) >>> 16) + cc;
    r = ((r * t) >>> 16) + cb;
    r = ((r * t) >>> 16) + ca;
    return r >>> 1;
  endfunction

  // Applies one accepted beat to the shadow store; returns 1 if a result is due.
  function automatic bit predict_height(input hbs_pkg::in_item_t it,
                                        output hbs_pkg::out_item_t o);
    longint ix, iz, tx, tz, res, h0, h1;
    longint rows [4];
    path_t p;
    o = '0;
    if (it.opcode == hbs_pkg::OP_WRITE) begin
      samples[it.sample_row * 128 + it.sample_col] = it.sample_value;
      return 0;
    end
    if (it.opcode == hbs_pkg::OP_NONE) return 0;
    locate(it, ix, iz, tx, tz, p);
    res = 0;
    case (p)
      PATH_CUBIC: begin
        for (int j = 0; j < 4; j++)
          rows[j] = spline(sample_at(iz - 1 + j, ix - 1), sample_at(iz - 1 + j, ix),
                           sample_at(iz - 1 + j, ix + 1), sample_at(iz - 1 + j, ix + 2), tx);
        res = spline(rows[0], rows[1], rows[2], rows[3], tz);
      end
      PATH_LIN: begin
        h0 = blend(sample_at(iz, ix), sample_at(iz, ix + 1), tx);
        h1 = blend(sample_at(iz + 1, ix), sample_at(iz + 1, ix + 1), tx);
        res = blend(h0, h1, tz);
      end
      default: res = 0;
    endcase
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    o = mk_out(res[31:0], p == PATH_OUT, p == PATH_CUBIC);
    return 1;
  endfunction

  // Beat monitor, result checker and stall watchdog.
  always @(posedge clk) begin
    note_t n;
    hbs_pkg::out_item_t o, e;
    if (!rst) begin
      idle_cycles++;
      if (in_ch.valid && in_ch.ready) begin
        idle_cycles = 0;
        n = note_q.pop_front();
        if (predict_height(in_ch.payload, o)) height_q.push_back(n.chk ? n.ex : o);
      end
      if (out_ch.valid && out_ch.ready) begin
        idle_cycles = 0;
        if (height_q.size() == 0) begin
          errs++;
          if (errs <= 10) $display("unexpected result beat %h", out_ch.payload);
        end else begin
          e = height_q.pop_front();
          if (out_ch.payload.height !== e.height ||
              out_ch.payload.out_of_range !== e.out_of_range ||
              out_ch.payload.used_bicubic !== e.used_bicubic) begin
            errs++;
            if (errs <= 10)
              $display("mismatch: expected h=%h oor=%b bic=%b, got h=%h oor=%b bic=%b",
                       e.height, e.out_of_range, e.used_bicubic, out_ch.payload.height,
                       out_ch.payload.out_of_range, out_ch.payload.used_bicubic);
          end
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Receiver: changing stall pattern, with a long hold-off when one is requested.
  initial begin
    int mode, mode_left;
    mode = 0;
    mode_left = 0;
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_ch.ready <= 0;
        repeat (400) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0: out_ch.ready <= 1;
          1: out_ch.ready <= $urandom_range(0, 1);
          2: out_ch.ready <= ($urandom_range(0, 9) == 0);
          default: out_ch.ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  task automatic send(hbs_pkg::in_item_t it, bit chk, hbs_pkg::out_item_t ex);
    int gap;
    note_t n;
    sent++;
    if (it.opcode == hbs_pkg::OP_WRITE) filled[it.sample_row * 128 + it.sample_col] = 1;
    n.chk = chk;
    n.ex = ex;
    note_q.push_back(n);
    in_ch.valid <= 1;
    in_ch.payload <= it;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(0, 12);
      if (gap > 0) begin
        in_ch.valid <= 0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic idle_in();
    in_ch.valid <= 0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (note_q.size() != 0 || height_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(hbs_pkg::reg_index_t idx, logic [31:0] d);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(negedge clk);
  endtask

  task automatic set_config(logic [31:0] ox, logic [31:0] oz, int inv, int w, int h);
    org_x = longint'(signed'(ox));
    org_z = longint'(signed'(oz));
    inv_cell = inv & 16'hFFFF;
    grid_w = w & 8'hFF;
    grid_h = h & 8'hFF;
    write_reg(hbs_pkg::REG_ORIGIN_X, ox);
    write_reg(hbs_pkg::REG_ORIGIN_Z, oz);
    write_reg(hbs_pkg::REG_INV_CELL, inv);
    write_reg(hbs_pkg::REG_GRID_W, w);
    write_reg(hbs_pkg::REG_GRID_H, h);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] sample_val();
    int k;
    k = $urandom_range(0, 9);
    if (k < 5) return $urandom;
    if (k < 9) return $urandom_range(0, 32'h1FFFFF) - 32'h100000;
    return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
  endfunction

  // Issues a query, first loading any sample it would read that is still unwritten.
  task automatic ask_height(hbs_pkg::opcode_t op, logic [31:0] x, logic [31:0] z);
    hbs_pkg::in_item_t it;
    longint ix, iz, tx, tz, r0, c0;
    path_t p;
    int span;
    it = mk_in(op, x, z, $urandom_range(0, 127), $urandom_range(0, 127), $urandom);
    locate(it, ix, iz, tx, tz, p);
    if (p != PATH_OUT) begin
      span = (p == PATH_CUBIC) ? 4 : 2;
      r0 = (p == PATH_CUBIC) ? iz - 1 : iz;
      c0 = (p == PATH_CUBIC) ? ix - 1 : ix;
      for (int r = 0; r < span; r++)
        for (int c = 0; c < span; c++)
          if (!filled[(r0 + r) * 128 + c0 + c])
            send(mk_in(hbs_pkg::OP_WRITE, 0, 0, r0 + r, c0 + c, sample_val()), 0, '0);
    end
    send(it, 0, '0);
  endtask

  function automatic logic [31:0] aim(longint org, int cells);
    longint g;
    g = longint'($urandom_range(0, cells + 1)) - 1;
    g = g * 64'sd16777216 + $urandom_range(0, 24'hFFFFFF);
    if (inv_cell == 0 || $urandom_range(0, 9) < 3) return $urandom;
    return org + g / inv_cell;
  endfunction

  initial begin
    row_t dirs[$];
    row_t d;
    int span_w, span_h, k, n;
    hbs_pkg::opcode_t op;
    rst = 1;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 0;
    in_ch.payload = '0;
    hold_req = 0;
    errs = 0;
    idle_cycles = 0;
    burst_left = 0;
    sent = 0;
    org_x = 0;
    org_z = 0;
    inv_cell = 1024;
    grid_w = 128;
    grid_h = 128;
    repeat (8) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Reset configuration: one cell is 0.25 world units, 128 by 128 grid.
    dirs.push_back('{mk_in(hbs_pkg::OP_WRITE, 0, 0, 0, 0, 32'h7FFFFFFF), 0, '0});
    dirs.push_back('{mk_in(hbs_pkg::OP_WRITE, 0, 0, 0, 1, 32'h80000000), 0, '0});
    dirs.push_back('{mk_in(hbs_pkg::OP_WRITE, 0, 0, 1, 0, 32'h80000000), 0, '0});
    dirs.push_back('{mk_in(hbs_pkg::OP_WRITE, 0, 0, 1, 1, 32'h00000000), 0, '0});
    dirs.push_back('{mk_in(hbs_pkg::OP_BILINEAR, 0, 0, 0, 0, 0), 1,
                     mk_out(32'h7FFFFFFF, 0, 0)});
    dirs.push_back('{mk_in(hbs_pkg::OP_BICUBIC, 0, 0, 0, 0, 0), 1,
                     mk_out(32'h7FFFFFFF, 0, 0)});
    dirs.push_back('{mk_in(hbs_pkg::OP_BILINEAR, 32'h2000, 32'h2000, 0, 0, 0), 0, '0});
    dirs.push_back('{mk_in(hbs_pkg::OP_BICUBIC, 32'h3FFF, 32'h1000, 0, 0, 0), 0, '0});
    dirs.push_back('{mk_in(hbs_pkg::OP_BILINEAR, 32'hFFFFFFFF, 0, 0, 0, 0), 1,
                     mk_out(0, 1, 0)});
    dirs.push_back('{mk_in(hbs_pkg::OP_BICUBIC, 0, 32'hFFFFFFFF, 0, 0, 0), 1,
                     mk_out(0, 1, 0)});
    dirs.push_back('{mk_in(hbs_pkg::OP_BILINEAR, 32'h7FFFFFFF, 0, 0, 0, 0), 1,
                     mk_out(0, 1, 0)});
    dirs.push_back('{mk_in(hbs_pkg::OP_BILINEAR, 0, 32'h80000000, 0, 0, 0), 1,
                     mk_out(0, 1, 0)});
    dirs.push_back('{mk_in(hbs_pkg::OP_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 127, 127,
                           32'hFFFFFFFF), 0, '0});
    dirs.push_back('{mk_in(hbs_pkg::OP_WRITE, 0, 0, 126, 126, 32'h00010000), 0, '0});
    dirs.push_back('{mk_in(hbs_pkg::OP_WRITE, 0, 0, 126, 127, 32'hFFFF0000), 0, '0});
    dirs.push_back('{mk_in(hbs_pkg::OP_WRITE, 0, 0, 127, 126, 32'h7FFFFFFF), 0, '0});
    dirs.push_back('{mk_in(hbs_pkg::OP_WRITE, 0, 0, 127, 127, 32'h80000000), 0, '0});
    // Edge fallback at the far corner, then one cell beyond it.
    dirs.push_back('{mk_in(hbs_pkg::OP_BICUBIC, 32'h1FA000, 32'h1FB000, 0, 0, 0), 0, '0});
    dirs.push_back('{mk_in(hbs_pkg::OP_BILINEAR, 32'h1FBFFF, 32'h1F8000, 0, 0, 0), 0, '0});
    dirs.push_back('{mk_in(hbs_pkg::OP_BILINEAR, 32'h1FC000, 32'h1F8000, 0, 0, 0), 1,
                     mk_out(0, 1, 0)});
    foreach (dirs[i]) begin
      d = dirs[i];
      send(d.it, d.chk, d.ex);
    end

    for (int ph = 0; ph < 10; ph++) begin
      idle_in();
      drain();
      case (ph)
        0: set_config(0, 0, 256, 6, 5);
        1: set_config($urandom, $urandom, 512, 8, 8);
        2: set_config(32'h80000000, 32'h7FFFFFFF, 65535, 2, 2);
        3: set_config($urandom_range(0, 32'hFFFF), 0, 1, 128, 128);
        4: set_config($urandom, $urandom, 0, 4, 4);
        5: set_config($urandom, $urandom, $urandom_range(1, 65535), 255, 200);
        6: set_config($urandom, $urandom, $urandom_range(1, 65535), 1, 0);
        9: set_config(32'h7FFFFFFF, 32'h80000000, 1024, 128, 3);
        default: set_config($urandom, $urandom, $urandom_range(1, 65535),
                            $urandom_range(2, 20), $urandom_range(2, 20));
      endcase
      // The first random phase starts with the receiver held off.
      if (ph == 1) hold_req = 1;
      span_w = grid_w > 128 ? 128 : grid_w;
      span_h = grid_h > 128 ? 128 : grid_h;
      n = 0;
      // Each phase runs until its share of beats, fill writes included, is sent.
      while (sent < 20 + (ph + 1) * 193) begin
        if (ph == 3 && n == 10) begin
          idle_in();
          drain();
        end
        n++;
        k = $urandom_range(0, 99);
        if (k < 15) begin
          send(mk_in(hbs_pkg::OP_WRITE, $urandom, $urandom, $urandom_range(0, 127),
                     $urandom_range(0, 127), sample_val()), 0, '0);
        end else if (k < 18) begin
          send(mk_in(hbs_pkg::OP_NONE, $urandom, $urandom, $urandom_range(0, 127),
                     $urandom_range(0, 127), $urandom), 0, '0);
        end else begin
          op = (k < 50) ? hbs_pkg::OP_BILINEAR : hbs_pkg::OP_BICUBIC;
          ask_height(op, aim(org_x, span_w), aim(org_z, span_h));
        end
      end
    end

    idle_in();
    while (note_q.size() != 0 || height_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (errs == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
